@@ hdl/nptte_pkg.sv @@
// Package for the prefix table TLV encoder: command, status and CSR index codes,
// the BR ID reset value, the maximum prefix length and the FSM state type. No dependencies.
`default_nettype none
package nptte_pkg;
   localparam logic [1:0] CMD_PUBLISH   = 2'd0;
   localparam logic [1:0] CMD_UNPUBLISH = 2'd1;
   localparam logic [1:0] CMD_EMIT      = 2'd2;
   localparam logic [1:0] CMD_NOP       = 2'd3;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_FULL      = 2'd1;
   localparam logic [1:0] ST_NO_GROUP  = 2'd2;
   localparam logic [1:0] ST_BAD_LEN   = 2'd3;

   localparam logic CSR_BR_ID  = 1'b0;
   localparam logic CSR_DOMAIN = 1'b1;

   localparam logic [15:0] BR_ID_RESET = 16'hfffe;
   localparam logic [7:0]  MAX_LEN     = 8'd128;

   typedef enum logic [3:0] {
      S_IDLE, S_PUB, S_UNPUB, S_GRP_I, S_GRP_J, S_GRP_SCAN, S_EMIT, S_DONE
   } state_type;
endpackage
`default_nettype wire

@@ hdl/nptte_ram.sv @@
// Generic single-port-write RAM with registered read.
// No dependencies.
`default_nettype none
module nptte_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]              rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

@@ hdl/network_prefix_table_tlv_encoder_core.sv @@
// Prefix table TLV encoder top level. Uses nptte_pkg and nptte_ram.
// Publish/unpublish scan the table entry by entry before giving their result; bad length
// and the spare command answer through S_DONE. Emit compares each group candidate with the
// earlier entries, then scans every entry for the group, then sends one byte per cycle.
// Throughput is one item at a time; busy is high from start until the last result.
// The single table memory port (one read per cycle) paces every scan.
// Reset (synchronous, active high) empties the table and restores the CSRs.
// Results cannot be stalled by the receiver.
`default_nettype none
module network_prefix_table_tlv_encoder_core #(
   parameter int TABLE_DEPTH = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [63:0] req_prefix_high,
   input  wire logic [63:0] req_prefix_low,
   input  wire logic [7:0]  req_prefix_length,
   input  wire logic        req_is_route,
   input  wire logic [9:0]  req_flags,
   input  wire logic signed [1:0] req_preference,
   input  wire logic [3:0]  req_group_index,
   output logic             rsp_valid,
   output logic [7:0]       rsp_data_byte,
   output logic             rsp_last,
   output logic [1:0]       rsp_status,
   output logic [4:0]       rsp_removed_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_wdata
);
   import nptte_pkg::*;
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = (CW > 4) ? CW : 4;   // group counter, at least group index wide
   localparam int EW = 149; // hi, lo, attr

   state_type state_ff, state_in;
   logic [15:0] br_ff;
   logic [7:0]  dom_ff;
   logic [CW-1:0] cnt_ff, cnt_in;
   // one cursor i, write pointer k, inner j; phase bit for the read latency
   logic [CW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic          ph_ff, ph_in;
   logic [1:0]  cmd_ff;
   logic [63:0] hi_ff, lo_ff;
   logic [20:0] attr_ff;
   logic [3:0]  gidx_ff;
   logic [SW-1:0] seen_ff, seen_in;
   logic [EW-1:0] ent_ff, ent_in;   // group key entry / held entry i
   logic [20:0] mesh_ff, mesh_in, rt_ff, rt_in;
   logic        hm_ff, hm_in, hr_ff, hr_in;
   logic [4:0]  bi_ff, bi_in;
   logic        ov_in, ol_in;
   logic [7:0]  ob_in;
   logic [1:0]  os_in;
   logic [4:0]  or_in;

   logic          we;
   logic [AW-1:0] waddr, raddr;
   logic [EW-1:0] wdata, rdata;

   nptte_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_tab (
      .clock(clock), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata));

   logic [63:0] r_hi, r_lo; logic [20:0] r_at;
   assign r_hi = rdata[148:85]; assign r_lo = rdata[84:21]; assign r_at = rdata[20:0];

   // shared compare unit: memory word against held key
   logic [63:0] k_hi, k_lo; logic [7:0] k_len;
   logic key_eq;
   always_comb begin
      if (state_ff == S_PUB || state_ff == S_UNPUB) begin
         k_hi = hi_ff; k_lo = lo_ff; k_len = attr_ff[7:0];
      end else begin
         k_hi = ent_ff[148:85]; k_lo = ent_ff[84:21]; k_len = ent_ff[7:0];
      end
      key_eq = (r_hi == k_hi) && (r_lo == k_lo) && (r_at[7:0] == k_len);
   end

   // TLV layout
   logic [4:0] nb, tot;
   logic [4:0] sub0;
   always_comb begin
      nb   = 5'((ent_ff[7:0] + 8'd7) >> 3);
      sub0 = 5'd4 + nb;
      tot  = sub0 + (hm_ff ? 5'd6 : 5'd0) + (hr_ff ? 5'd5 : 5'd0);
   end
   logic sm, sr;
   assign sm = hm_ff & mesh_ff[15];
   assign sr = hr_ff & rt_ff[15];
   logic [15:0] bw;
   logic [7:0]  pb;
   always_comb begin
      bw = '0;
      bw[15] = mesh_ff[9];  bw[14] = mesh_ff[10]; bw[13] = mesh_ff[11];
      bw[12] = mesh_ff[12]; bw[11] = mesh_ff[13]; bw[10] = mesh_ff[14];
      bw[9]  = mesh_ff[16]; bw[5:4] = mesh_ff[20:19];
      pb = {rt_ff[20:19], rt_ff[17], rt_ff[18], 4'd0};
   end
   logic [7:0] emit_b;
   logic [4:0] off, pk;
   always_comb begin
      emit_b = 8'd0; off = 5'd0; pk = bi_ff - 5'd4;
      // prefix TLV type 1 in bits 7:1, stable bit in bit 0
      if (bi_ff == 5'd0) emit_b = {6'd0, 1'b1, sm | sr};
      else if (bi_ff == 5'd1) emit_b = 8'(tot - 5'd2);
      else if (bi_ff == 5'd2) emit_b = dom_ff;
      else if (bi_ff == 5'd3) emit_b = ent_ff[7:0];
      else if (bi_ff < sub0) begin
         if (pk < 5'd8) emit_b = 8'(ent_ff[148:85] >> (6'd56 - {pk[2:0], 3'd0}));
         else emit_b = 8'(ent_ff[84:21] >> (6'd56 - {pk[2:0], 3'd0}));
      end else begin
         off = bi_ff - sub0;
         if (hm_ff && off < 5'd6) begin
            case (off[2:0])
               3'd0: emit_b = {7'd2, sm};
               3'd1: emit_b = 8'd4;
               3'd2: emit_b = br_ff[15:8];
               3'd3: emit_b = br_ff[7:0];
               3'd4: emit_b = bw[15:8];
               default: emit_b = bw[7:0];
            endcase
         end else begin
            if (hm_ff) off = off - 5'd6;
            case (off[2:0])
               3'd0: emit_b = {7'd0, sr};
               3'd1: emit_b = 8'd3;
               3'd2: emit_b = br_ff[15:8];
               3'd3: emit_b = br_ff[7:0];
               default: emit_b = pb;
            endcase
         end
      end
   end

   logic accept;
   assign accept = start && !busy;
   assign busy = (state_ff != S_IDLE);
   assign csr_ready = !busy;
   logic [AW-1:0] ia, ja, ka;
   assign ia = i_ff[AW-1:0]; assign ja = j_ff[AW-1:0]; assign ka = k_ff[AW-1:0];

   // next state; states that give their own result return straight to idle
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) begin
            if (req_cmd == CMD_PUBLISH && req_prefix_length <= MAX_LEN) state_in = S_PUB;
            else if (req_cmd == CMD_UNPUBLISH && req_prefix_length <= MAX_LEN)
               state_in = S_UNPUB;
            else if (req_cmd == CMD_EMIT) state_in = S_GRP_I;
            else state_in = S_DONE;
         end
         S_PUB:   if (i_ff >= cnt_ff || (ph_ff && key_eq && r_at[8] == attr_ff[8]))
                     state_in = S_IDLE;
         S_UNPUB: if (i_ff >= cnt_ff) state_in = S_IDLE;
         S_GRP_I: if (i_ff >= cnt_ff) state_in = S_IDLE;
                  else if (ph_ff) state_in = S_GRP_J;
         S_GRP_J: if (j_ff >= i_ff)
                     state_in = (seen_ff == SW'(gidx_ff)) ? S_GRP_SCAN : S_GRP_I;
                  else if (ph_ff && key_eq) state_in = S_GRP_I;
         S_GRP_SCAN: if (i_ff >= cnt_ff) state_in = S_EMIT;
         S_EMIT:  if (bi_ff == tot - 5'd1) state_in = S_IDLE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath / outputs
   always_comb begin
      i_in = i_ff; j_in = j_ff; k_in = k_ff; ph_in = 1'b0; cnt_in = cnt_ff;
      seen_in = seen_ff; ent_in = ent_ff;
      mesh_in = mesh_ff; rt_in = rt_ff; hm_in = hm_ff; hr_in = hr_ff; bi_in = bi_ff;
      ov_in = 1'b0; ol_in = 1'b0; ob_in = 8'd0; os_in = ST_OK; or_in = 5'd0;
      we = 1'b0; waddr = ka; wdata = rdata; raddr = ia;
      unique case (state_ff)
         S_IDLE: begin
            i_in = '0; j_in = '0; k_in = '0; seen_in = '0;
            hm_in = 1'b0; hr_in = 1'b0; bi_in = '0;
         end
         S_PUB: begin
            if (!ph_ff) ph_in = (i_ff < cnt_ff);
            if (i_ff >= cnt_ff) begin
               ov_in = 1'b1; ol_in = 1'b1;
               if (cnt_ff >= CW'(TABLE_DEPTH)) os_in = ST_FULL;
               else begin
                  we = 1'b1; waddr = cnt_ff[AW-1:0]; wdata = {hi_ff, lo_ff, attr_ff};
                  cnt_in = cnt_ff + 1'b1;
               end
            end else if (ph_ff) begin
               if (key_eq && r_at[8] == attr_ff[8]) begin
                  we = 1'b1; waddr = ia; wdata = {hi_ff, lo_ff, attr_ff};
                  ov_in = 1'b1; ol_in = 1'b1;
               end else i_in = i_ff + 1'b1;
            end
         end
         S_UNPUB: begin
            if (i_ff >= cnt_ff) begin
               cnt_in = k_ff; ov_in = 1'b1; ol_in = 1'b1;
               or_in = 5'(i_ff - k_ff);
            end else if (!ph_ff) ph_in = 1'b1;
            else begin
               i_in = i_ff + 1'b1;
               if (!key_eq) begin
                  we = 1'b1; waddr = ka; wdata = rdata; k_in = k_ff + 1'b1;
               end
            end
         end
         S_GRP_I: begin
            raddr = ia;
            if (i_ff >= cnt_ff) begin
               ov_in = 1'b1; ol_in = 1'b1; os_in = ST_NO_GROUP;
            end else if (!ph_ff) ph_in = 1'b1;
            else begin
               ent_in = rdata; j_in = '0;
            end
         end
         S_GRP_J: begin
            raddr = ja;
            if (j_ff >= i_ff) begin
               seen_in = seen_ff + 1'b1;
               if (seen_ff != SW'(gidx_ff)) i_in = i_ff + 1'b1;
            end else if (!ph_ff) ph_in = 1'b1;
            else if (key_eq) i_in = i_ff + 1'b1;
            else j_in = j_ff + 1'b1;
         end
         S_GRP_SCAN: begin
            raddr = ia;
            if (i_ff < cnt_ff) begin
               if (!ph_ff) ph_in = 1'b1;
               else begin
                  i_in = i_ff + 1'b1;
                  if (key_eq) begin
                     if (r_at[8]) begin rt_in = r_at; hr_in = 1'b1; end
                     else begin mesh_in = r_at; hm_in = 1'b1; end
                  end
               end
            end
         end
         S_EMIT: begin
            ov_in = 1'b1; ob_in = emit_b; ol_in = (bi_ff == tot - 5'd1);
            bi_in = bi_ff + 1'b1;
         end
         S_DONE: begin
            ov_in = 1'b1; ol_in = 1'b1;
            os_in = ((cmd_ff == CMD_PUBLISH || cmd_ff == CMD_UNPUBLISH) &&
                     attr_ff[7:0] > MAX_LEN) ? ST_BAD_LEN : ST_OK;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; cnt_ff <= '0; br_ff <= BR_ID_RESET; dom_ff <= '0;
         rsp_valid <= 1'b0;
      end else begin
         state_ff <= state_in; cnt_ff <= cnt_in; rsp_valid <= ov_in;
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_BR_ID) br_ff <= csr_wdata;
            else dom_ff <= csr_wdata[7:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      i_ff <= i_in; j_ff <= j_in; k_ff <= k_in; ph_ff <= ph_in;
      seen_ff <= seen_in; ent_ff <= ent_in;
      mesh_ff <= mesh_in; rt_ff <= rt_in; hm_ff <= hm_in; hr_ff <= hr_in; bi_ff <= bi_in;
      rsp_data_byte <= ob_in; rsp_last <= ol_in; rsp_status <= os_in;
      rsp_removed_count <= or_in;
      if (accept) begin
         cmd_ff <= req_cmd; hi_ff <= req_prefix_high; lo_ff <= req_prefix_low;
         attr_ff <= {req_preference, req_flags, req_is_route, req_prefix_length};
         gidx_ff <= req_group_index;
      end
   end
endmodule
`default_nettype wire
